/* rtl/core/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the scrolling line editor buffer.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Default sizes
    localparam int STORE_DEPTH = 32;
    localparam int ROW_COLUMNS = 16;

    // Field widths fixed by the item format
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 5;
    localparam int HINT_W   = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] CURSOR_RESET = 8'd95;
    localparam logic [HINT_W-1:0] HINT_RESET   = 4'd0;

    // Register select, taken from paddr[2]
    localparam logic REG_HINT   = 1'b0;
    localparam logic REG_CURSOR = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_RESET  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EMIT,
        ST_REFUSE
    } state_t;

    typedef struct packed {
        logic [HINT_W-1:0] hint;
        logic [CHAR_W-1:0] cursor;
    } cfg_t;

endpackage

/* rtl/core/sle_if.sv */
// ----------------------------------------------------------------------------
// sle_if
// Handshake channels: key items in, display write items out.
// ----------------------------------------------------------------------------
interface sle_key_if;
    logic                         valid;
    logic                         ready;
    logic [sle_pkg::KIND_W-1:0]   kind;
    logic [sle_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output kind, output char_in, input ready);
    modport sink   (input valid, input kind, input char_in, output ready);
endinterface

interface sle_disp_if;
    logic                         valid;
    logic                         ready;
    logic [sle_pkg::COL_W-1:0]    column;
    logic [sle_pkg::CHAR_W-1:0]   char_out;
    logic                         write_valid;
    logic                         error;
    logic                         last;

    modport source (output valid, output column, output char_out, output write_valid,
                    output error, output last, input ready);
    modport sink   (input valid, input column, input char_out, input write_valid,
                    input error, input last, output ready);
endinterface

/* rtl/core/sle_store.sv */
// ----------------------------------------------------------------------------
// sle_store
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sle_store #(
    parameter int DEPTH  = sle_pkg::STORE_DEPTH,
    parameter int ADDR_W = 5
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [sle_pkg::CHAR_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [sle_pkg::CHAR_W-1:0]  rd_data
);

    logic [sle_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [sle_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/sle_pick.sv */
// ----------------------------------------------------------------------------
// sle_pick
// Glyph unit: compare the scan index with the fill count and select the
// stored character, the cursor or a space.
// ----------------------------------------------------------------------------
module sle_pick #(
    parameter int VW = 6
) (
    input  logic [VW-1:0]               idx,
    input  logic [VW-1:0]               fill,
    input  logic [sle_pkg::CHAR_W-1:0]  rd_data,
    input  logic [sle_pkg::CHAR_W-1:0]  cursor,
    output logic [sle_pkg::CHAR_W-1:0]  glyph
);

    always_comb
    begin
        if (idx < fill)
        begin
            glyph = rd_data;
        end
        else if (idx == fill)
        begin
            glyph = cursor;
        end
        else
        begin
            glyph = sle_pkg::SPACE_CODE;
        end
    end

endmodule

/* rtl/core/sle_ctrl.sv */
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: apply the key operation to the stack, then walk the row one
// column per cycle through the shared glyph unit, unless disp stalls.
// ----------------------------------------------------------------------------
module sle_ctrl #(
    parameter int STORE_DEPTH = sle_pkg::STORE_DEPTH,
    parameter int ROW_COLUMNS = sle_pkg::ROW_COLUMNS,
    parameter int ADDR_W      = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // key side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sle_pkg::KIND_W-1:0]  in_kind,
    input  logic [sle_pkg::CHAR_W-1:0]  in_char,
    // configuration
    input  sle_pkg::cfg_t               cfg,
    output logic                        hint_clr,
    // display side
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sle_pkg::COL_W-1:0]   column,
    output logic [sle_pkg::CHAR_W-1:0]  char_out,
    output logic                        write_valid,
    output logic                        error,
    output logic                        last,
    // store
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [sle_pkg::CHAR_W-1:0]  wr_data,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [sle_pkg::CHAR_W-1:0]  rd_data
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int BIG   = (STORE_DEPTH > ROW_COLUMNS) ? STORE_DEPTH : ROW_COLUMNS;
    localparam int VW0   = $clog2(BIG + 1);
    localparam int VW    = (VW0 > sle_pkg::COL_W) ? VW0 : sle_pkg::COL_W;

    localparam logic [VW-1:0]    LAST_COL  = VW'(ROW_COLUMNS);
    localparam logic [VW-1:0]    MAX_HINT  = VW'(ROW_COLUMNS - 1);
    localparam logic [VW-1:0]    DEPTH_V   = VW'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STORE_DEPTH);

    sle_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             err_reg, err_next;
    logic [VW-1:0]    idx_reg, idx_next;
    logic [VW-1:0]    col_reg, col_next;

    logic [VW-1:0]    hint_c;
    logic [VW-1:0]    visible;
    logic [VW-1:0]    fill_w;
    logic [VW-1:0]    first;
    logic [sle_pkg::CHAR_W-1:0] glyph;
    logic             accept;
    logic             at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::ST_IDLE;
            fill_reg  <= '0;
            err_reg   <= 1'b0;
            idx_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
            idx_reg   <= idx_next;
            col_reg   <= col_next;
        end
    end

    // Window start: clamp the hint, then skip the oldest entries that do not fit
    assign hint_c  = (VW'(cfg.hint) > MAX_HINT) ? MAX_HINT : VW'(cfg.hint);
    assign visible = MAX_HINT - hint_c;
    assign fill_w  = VW'(fill_reg);
    assign first   = (fill_w > visible) ? (fill_w - visible) : '0;

    assign accept  = in_valid && in_ready;
    assign at_last = (col_reg == LAST_COL);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        col_next   = col_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        hint_clr   = 1'b0;
        wr_en      = 1'b0;

        case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    state_next = sle_pkg::ST_PREP;
                    case (sle_pkg::kind_t'(in_kind))
                        sle_pkg::KIND_INSERT:
                        begin
                            if (fill_reg == FULL_CNT)
                            begin
                                err_next   = 1'b1;
                                state_next = sle_pkg::ST_REFUSE;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        sle_pkg::KIND_DELETE:
                        begin
                            if (fill_reg == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = sle_pkg::ST_REFUSE;
                            end
                            else
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        sle_pkg::KIND_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            fill_next = '0;
                            err_next  = 1'b0;
                            hint_clr  = 1'b1;
                        end
                    endcase
                end
            end
            sle_pkg::ST_PREP:
            begin
                idx_next   = first;
                col_next   = hint_c + 1'b1;
                state_next = sle_pkg::ST_EMIT;
            end
            sle_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (at_last)
                    begin
                        state_next = sle_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            sle_pkg::ST_REFUSE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = sle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

    // Read ahead at the next index so the data lines up with idx_reg
    assign rd_addr = (idx_next < DEPTH_V) ? idx_next[ADDR_W-1:0] : '0;
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = in_char;

    sle_pick #(
        .VW (VW)
    ) u_pick (
        .idx     (idx_reg),
        .fill    (fill_w),
        .rd_data (rd_data),
        .cursor  (cfg.cursor),
        .glyph   (glyph)
    );

    assign write_valid = (state_reg == sle_pkg::ST_EMIT);
    assign column      = write_valid ? col_reg[sle_pkg::COL_W-1:0] : '0;
    assign char_out    = write_valid ? glyph : '0;
    assign error       = err_reg;
    assign last        = (state_reg == sle_pkg::ST_REFUSE) || at_last;

endmodule

/* rtl/core/scrolling_line_editor_buffer.sv */
// ----------------------------------------------------------------------------
// scrolling_line_editor_buffer
// Line editor for one display row: character stack, fill count, sticky
// error flag, and a column-by-column redraw after every key item.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+----------------------------------
//  key       | in        | valid / ready    | kind, char_in
//  disp      | out       | valid / ready    | column, char_out, write_valid,
//            |           |                  | error, last
//  APB       | in        | psel / penable   | paddr, pwdata, prdata
//
//  An accepted key item updates the stack in the accepting cycle, sets up
//  the scan window in PREP, then offers one display item per cycle, while
//  disp is ready, for columns hint_len + 1 up to ROW_COLUMNS (hint_len
//  clamped to ROW_COLUMNS - 1). A refused item offers its single display
//  item in the cycle after acceptance.
//  The scan shares one glyph select unit and the single read port of the
//  entry store.
//  Reset clears the sequencer, fill count, error flag and registers; the
//  entry store holds no reset and its data is only used below the fill count.
//  A stall on disp holds the current display item; key stays not ready
//  until the last display item of an item is taken.
//
module scrolling_line_editor_buffer #(
    parameter int STORE_DEPTH = sle_pkg::STORE_DEPTH,
    parameter int ROW_COLUMNS = sle_pkg::ROW_COLUMNS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sle_key_if.sink                       key,
    sle_disp_if.source                    disp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sle_pkg::PADDR_W-1:0]   paddr,
    input  logic [sle_pkg::PDATA_W-1:0]   pwdata,
    output logic [sle_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Configuration registers
    logic [sle_pkg::HINT_W-1:0] hint_reg;
    logic [sle_pkg::CHAR_W-1:0] cursor_reg;
    logic                       cfg_wr;
    logic                       hint_clr;
    sle_pkg::cfg_t              cfg;

    // Store port
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [sle_pkg::CHAR_W-1:0] wr_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic [sle_pkg::CHAR_W-1:0] rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Writes must arrive only while idle (the block does not enforce it); a reset-op clear wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg   <= sle_pkg::HINT_RESET;
            cursor_reg <= sle_pkg::CURSOR_RESET;
        end
        else if (hint_clr)
        begin
            hint_reg <= sle_pkg::HINT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == sle_pkg::REG_HINT)
            begin
                hint_reg <= pwdata[sle_pkg::HINT_W-1:0];
            end
            else
            begin
                cursor_reg <= pwdata[sle_pkg::CHAR_W-1:0];
            end
        end
    end

    // Read back the selected register, zero-extended
    assign prdata = (paddr[2] == sle_pkg::REG_CURSOR)
                  ? sle_pkg::PDATA_W'(cursor_reg)
                  : sle_pkg::PDATA_W'(hint_reg);

    assign cfg.hint   = hint_reg;
    assign cfg.cursor = cursor_reg;

    sle_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sle_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .ROW_COLUMNS (ROW_COLUMNS),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (key.valid),
        .in_ready    (key.ready),
        .in_kind     (key.kind),
        .in_char     (key.char_in),
        .cfg         (cfg),
        .hint_clr    (hint_clr),
        .out_valid   (disp.valid),
        .out_ready   (disp.ready),
        .column      (disp.column),
        .char_out    (disp.char_out),
        .write_valid (disp.write_valid),
        .error       (disp.error),
        .last        (disp.last),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

endmodule

/* rtl/core/sle_chk.sv */
// ----------------------------------------------------------------------------
// sle_chk
// Port-level checks for the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module sle_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         key_valid,
    input logic                         key_ready,
    input logic                         disp_valid,
    input logic                         disp_ready,
    input logic [sle_pkg::COL_W-1:0]    disp_column,
    input logic                         disp_write_valid,
    input logic                         disp_error,
    input logic                         disp_last
);

    // A refusal always carries the error flag and closes the item
    a_refuse_flags: assert property (@(posedge clk) disp_valid && !disp_write_valid
                                     |-> disp_error && disp_last)
        else $error("refused item without error or last");

    // No new key item while a display item is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
                                   disp_valid |-> !key_ready)
        else $error("key ready while display item pending");

    // A write never targets column zero
    a_col_nonzero: assert property (@(posedge clk) disp_valid && disp_write_valid
                                    |-> disp_column != '0)
        else $error("display write to column zero");

    // Accepting a key item drops ready on the next cycle
    a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
                                       key_valid && key_ready |=> !key_ready)
        else $error("key ready straight after acceptance");

    // Taking the last display item frees the key side
    a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
                                        disp_valid && disp_ready && disp_last |=> key_ready)
        else $error("key not ready after last display item");

endmodule

bind scrolling_line_editor_buffer sle_chk u_sle_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .key_valid        (key.valid),
    .key_ready        (key.ready),
    .disp_valid       (disp.valid),
    .disp_ready       (disp.ready),
    .disp_column      (disp.column),
    .disp_write_valid (disp.write_valid),
    .disp_error       (disp.error),
    .disp_last        (disp.last)
);
